// ----- design/trk_pkg.sv -----
package trk_pkg;

    // Frame geometry
    localparam int VALUE_COUNT = 19;
    localparam int STORE_DEPTH = 4 * VALUE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 5;
    localparam int VALUE_W = 32;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SOURCE_RST  = 8'h11;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Payload store write beat
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

    // Decoded frame value from the emitter
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_rec;

endpackage

// ----- design/trk_in_if.sv -----
interface trk_in_if;
    import trk_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

// ----- design/trk_out_if.sv -----
interface trk_out_if;
    import trk_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      is_record;
    logic [IDX_W-1:0]          record_index;
    logic signed [VALUE_W-1:0] record_value;
    logic                      last_record;
    logic                      online;

    modport source (output valid, output is_record, output record_index,
                    output record_value, output last_record, output online,
                    input ready);
    modport sink   (input valid, input is_record, input record_index,
                    input record_value, input last_record, input online,
                    output ready);
endinterface

// ----- design/tracking_frame_receiver_core.sv -----
// Serial frame receiver with an additive checksum and a link watchdog. Each input
// beat is a received byte or a tick. A frame is header, source, destination,
// function, length L, L payload bytes and a checksum equal to the 8-bit sum of
// all earlier bytes; a good frame with at least 76 payload bytes gives 19 beats
// of big-endian signed 32-bit values, the last one flagged. Every tick gives one
// status beat with the online flag, which drops after timeout_ticks ticks with
// no good frame. Bytes and ticks are taken one per cycle while no frame is being
// emitted and the output register is free. After a good frame the input stalls
// while the payload store, a single-read-port memory, is walked byte by byte,
// each byte in a read state and then a shift state; each gathered value then
// waits in a hold state until the output register is free to take it.
// Configuration: index 0 header byte, 1 source byte, 2 timeout ticks.
module tracking_frame_receiver_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    trk_in_if.sink                        i_in,
    trk_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [trk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [trk_pkg::CFG_W-1:0]     i_cfg_data
);
    import trk_pkg::*;

    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_source;
    logic [TICK_W-1:0] r_timeout;
    logic [TICK_W-1:0] r_silent;
    logic              r_online;
    logic              n_online;

    logic                r_out_valid;
    logic                r_out_is_record;
    logic [IDX_W-1:0]    r_out_index;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;
    logic                r_out_online;

    logic              out_free;
    logic              emit_busy;
    logic              accept;
    logic              byte_en;
    logic              tick_en;
    logic              good;
    logic              take;
    t_wr               wr;
    t_rec              rec;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // Handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = !emit_busy && out_free;
    assign accept     = i_in.valid && i_in.ready;
    assign byte_en    = accept && (i_in.kind == KIND_BYTE);
    assign tick_en    = accept && (i_in.kind == KIND_TICK);
    assign take       = rec.valid && out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RST;
            r_source  <= SOURCE_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER:  r_header  <= i_cfg_data[BYTE_W-1:0];
                CFG_SOURCE:  r_source  <= i_cfg_data[BYTE_W-1:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Watchdog: count silent ticks, clear on a good frame
    assign n_online = (r_silent < r_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silent <= '0;
            r_online <= 1'b0;
        end else if (tick_en) begin
            r_online <= n_online;
            if (n_online) begin
                r_silent <= r_silent + 1'b1;
            end
        end else if (good) begin
            r_silent <= '0;
        end
    end

    // Output register: tick status or frame value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_en) begin
            r_out_valid <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_en) begin
            r_out_is_record <= 1'b0;
            r_out_index     <= '0;
            r_out_value     <= '0;
            r_out_last      <= 1'b0;
            r_out_online    <= n_online;
        end else if (take) begin
            r_out_is_record <= 1'b1;
            r_out_index     <= rec.index;
            r_out_value     <= rec.value;
            r_out_last      <= rec.last;
            r_out_online    <= r_online;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_record    = r_out_is_record;
    assign o_out.record_index = r_out_index;
    assign o_out.record_value = r_out_value;
    assign o_out.last_record  = r_out_last;
    assign o_out.online       = r_out_online;

    trk_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_byte    (i_in.byte_value),
        .i_header  (r_header),
        .i_source  (r_source),
        .o_wr      (wr),
        .o_good    (good)
    );

    trk_payload_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    trk_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (good),
        .i_rd_data (rd_data),
        .i_take    (take),
        .o_rd_addr (rd_addr),
        .o_rec     (rec),
        .o_busy    (emit_busy)
    );
endmodule

// ----- design/trk_payload_ram.sv -----
module trk_payload_ram (
    input  logic                           i_clk,
    input  trk_pkg::t_wr                   i_wr,
    input  logic [trk_pkg::ADDR_W-1:0]     i_rd_addr,
    output logic [trk_pkg::BYTE_W-1:0]     o_rd_data
);
    import trk_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- design/trk_parser.sv -----
module trk_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_byte_en,
    input  logic [trk_pkg::BYTE_W-1:0] i_byte,
    input  logic [trk_pkg::BYTE_W-1:0] i_header,
    input  logic [trk_pkg::BYTE_W-1:0] i_source,
    output trk_pkg::t_wr               o_wr,
    output logic                       o_good
);
    import trk_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE = 3'd0,
        P_HDR  = 3'd1,
        P_SRC  = 3'd2,
        P_DST  = 3'd3,
        P_FUNC = 3'd4,
        P_PAY  = 3'd5,
        P_CHK  = 3'd6
    } t_phase;

    t_phase            r_phase;
    logic [BYTE_W-1:0] r_remaining;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_count;

    // Store payload bytes that fit in the value area
    always_comb begin
        o_wr.en   = i_byte_en && (r_phase == P_PAY) && (r_remaining != '0)
                    && (r_count < BYTE_W'(STORE_DEPTH));
        o_wr.addr = r_count[ADDR_W-1:0];
        o_wr.data = i_byte;
    end

    // Good frame: checksum matches and the value area is full
    assign o_good = i_byte_en && (r_phase == P_CHK) && (i_byte == r_sum)
                    && (r_count >= BYTE_W'(STORE_DEPTH));

    // Frame state machine, one step per received byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_remaining <= '0;
            r_sum       <= '0;
            r_count     <= '0;
        end else if (i_byte_en) begin
            case (r_phase)
                P_IDLE: begin
                    if (i_byte == i_header) begin
                        r_phase <= P_HDR;
                        r_sum   <= i_byte;
                    end
                end
                P_HDR: begin
                    if (i_byte == i_source) begin
                        r_phase <= P_SRC;
                        r_sum   <= r_sum + i_byte;
                    end else begin
                        r_phase <= P_IDLE;
                    end
                end
                P_SRC: begin
                    r_phase <= P_DST;
                    r_sum   <= r_sum + i_byte;
                end
                P_DST: begin
                    r_phase <= P_FUNC;
                    r_sum   <= r_sum + i_byte;
                end
                P_FUNC: begin
                    r_phase     <= P_PAY;
                    r_sum       <= r_sum + i_byte;
                    r_remaining <= i_byte;
                    r_count     <= '0;
                end
                P_PAY: begin
                    // Zero length swallows this byte and drops the frame
                    if (r_remaining == '0) begin
                        r_phase <= P_IDLE;
                    end else begin
                        r_count     <= r_count + 1'b1;
                        r_sum       <= r_sum + i_byte;
                        r_remaining <= r_remaining - 1'b1;
                        if (r_remaining == BYTE_W'(1)) begin
                            r_phase <= P_CHK;
                        end
                    end
                end
                P_CHK: begin
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- design/trk_emitter.sv -----
module trk_emitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [trk_pkg::BYTE_W-1:0] i_rd_data,
    input  logic                       i_take,
    output logic [trk_pkg::ADDR_W-1:0] o_rd_addr,
    output trk_pkg::t_rec              o_rec,
    output logic                       o_busy
);
    import trk_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_SHIFT,
        E_HOLD
    } t_estate;

    t_estate            r_state;
    logic [IDX_W-1:0]   r_val;
    logic [1:0]         r_sub;
    logic [VALUE_W-1:0] r_acc;

    // Byte address of the current value, big-endian order
    assign o_rd_addr = ADDR_W'({r_val, r_sub});
    assign o_busy    = (r_state != E_IDLE);

    always_comb begin
        o_rec.valid = (r_state == E_HOLD);
        o_rec.index = r_val;
        o_rec.value = r_acc;
        o_rec.last  = (r_val == IDX_W'(VALUE_COUNT - 1));
    end

    // Walk the store four bytes per value, hold each value until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_val   <= '0;
            r_sub   <= '0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_state <= E_READ;
                        r_val   <= '0;
                        r_sub   <= '0;
                    end
                end
                E_READ: begin
                    r_state <= E_SHIFT;
                end
                E_SHIFT: begin
                    r_acc <= {r_acc[VALUE_W-BYTE_W-1:0], i_rd_data};
                    if (r_sub == 2'd3) begin
                        r_state <= E_HOLD;
                    end else begin
                        r_sub   <= r_sub + 1'b1;
                        r_state <= E_READ;
                    end
                end
                E_HOLD: begin
                    if (i_take) begin
                        if (o_rec.last) begin
                            r_state <= E_IDLE;
                        end else begin
                            r_val   <= r_val + 1'b1;
                            r_sub   <= '0;
                            r_state <= E_READ;
                        end
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import trk_pkg::*;

    // One beat that the block is expected to emit
    typedef struct packed {
        logic                      is_record;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      online;
    } t_out_beat;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_SOURCE, PH_DEST, PH_FUNC, PH_PAYLOAD, PH_CHECK
    } t_parse_phase;

    typedef enum {
        SEQ_GOOD, SEQ_BAD_SUM, SEQ_SHORT, SEQ_ZERO_LEN, SEQ_WRONG_SOURCE
    } t_frame_shape;

    // Frame parser and watchdog predictor with the queue of beats still owed
    class t_frame_tracker;
        logic [BYTE_W-1:0] header_b;
        logic [BYTE_W-1:0] source_b;
        logic [TICK_W-1:0] timeout_t;
        t_parse_phase      phase;
        logic [BYTE_W-1:0] remaining;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] store [STORE_DEPTH];
        logic [TICK_W-1:0] silent;
        logic              online;
        t_out_beat         owed_beats [$];
        int                errors;

        function new();
            header_b  = HEADER_RST;
            source_b  = SOURCE_RST;
            timeout_t = TIMEOUT_RST;
            phase     = PH_IDLE;
            remaining = '0;
            sum       = '0;
            count     = '0;
            silent    = '0;
            online    = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_HEADER:  header_b = value[BYTE_W-1:0];
                CFG_SOURCE:  source_b = value[BYTE_W-1:0];
                CFG_TIMEOUT: timeout_t = value[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        function void owe(logic is_rec, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                          logic last);
            t_out_beat b;
            b.is_record = is_rec;
            b.index     = idx;
            b.value     = value;
            b.last      = last;
            b.online    = online;
            owed_beats.push_back(b);
        endfunction

        // Advance the parser and watchdog by one accepted input beat
        function void take_input(logic kind, logic [BYTE_W-1:0] b);
            logic [VALUE_W-1:0] word;
            if (kind == KIND_TICK) begin
                if (silent < timeout_t) begin
                    silent = silent + 1'b1;
                    online = 1'b1;
                end else begin
                    online = 1'b0;
                end
                owe(1'b0, '0, '0, 1'b0);
                return;
            end
            case (phase)
                PH_IDLE: begin
                    if (b == header_b) begin
                        phase = PH_HEADER;
                        sum   = b;
                    end
                end
                // a wrong source byte is dropped, not retried as a header
                PH_HEADER: begin
                    if (b == source_b) begin
                        phase = PH_SOURCE;
                        sum   = sum + b;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_SOURCE: begin
                    phase = PH_DEST;
                    sum   = sum + b;
                end
                PH_DEST: begin
                    phase = PH_FUNC;
                    sum   = sum + b;
                end
                PH_FUNC: begin
                    phase     = PH_PAYLOAD;
                    sum       = sum + b;
                    remaining = b;
                    count     = '0;
                end
                PH_PAYLOAD: begin
                    // zero length: swallow this byte and drop the frame
                    if (remaining == 0) begin
                        phase = PH_IDLE;
                    end else begin
                        if (count < STORE_DEPTH)
                            store[count] = b;
                        count     = count + 1'b1;
                        sum       = sum + b;
                        remaining = remaining - 1'b1;
                        if (remaining == 0)
                            phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase = PH_IDLE;
                    if (b == sum && count >= STORE_DEPTH) begin
                        for (int k = 0; k < VALUE_COUNT; k++) begin
                            word = {store[4*k], store[4*k+1], store[4*k+2], store[4*k+3]};
                            owe(1'b1, k[IDX_W-1:0], word, k == VALUE_COUNT - 1);
                        end
                        silent = '0;
                    end
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        // Compare one accepted output beat against the oldest owed beat
        task match_output(logic is_rec, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                          logic last, logic onl);
            t_out_beat want;
            if (owed_beats.size() == 0) begin
                report($sformatf("unexpected beat rec %0b idx %0d value %0d last %0b online %0b",
                                 is_rec, idx, $signed(value), last, onl));
                return;
            end
            want = owed_beats.pop_front();
            if (is_rec !== want.is_record || idx !== want.index || value !== want.value ||
                last !== want.last || onl !== want.online)
                report($sformatf({"got rec %0b idx %0d value %0d last %0b online %0b, ",
                                  "want rec %0b idx %0d value %0d last %0b online %0b"},
                                 is_rec, idx, $signed(value), last, onl,
                                 want.is_record, want.index, want.value, want.last,
                                 want.online));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    trk_in_if  in_ch ();
    trk_out_if out_ch ();

    t_frame_tracker tracker;
    int             beats_sent = 0;
    int             calm_left [2];

    tracking_frame_receiver_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Draw a wait in cycles; now and then run a stretch with no waits at all
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left[side] = $urandom_range(10, 60);
        return $urandom_range(0, 15);
    endfunction

    // Observe both channels at the clock edge: inputs first, then outputs
    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready)
            tracker.take_input(in_ch.kind, in_ch.byte_value);
        if (out_ch.valid && out_ch.ready)
            tracker.match_output(out_ch.is_record, out_ch.record_index, out_ch.record_value,
                                 out_ch.last_record, out_ch.online);
    end

    // Output sink: stall a random number of cycles before each beat
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap(1);
            repeat (gap) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_beat(input logic kind, input logic [BYTE_W-1:0] value);
        int gap;
        gap = draw_gap(0);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.byte_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Build one frame of the given shape and send it, with stray ticks mixed in
    task automatic send_frame(input t_frame_shape shape);
        logic [BYTE_W-1:0]  q [$];
        logic [BYTE_W-1:0]  len;
        logic [BYTE_W-1:0]  sum;
        logic [BYTE_W-1:0]  bad;
        logic [VALUE_W-1:0] word;
        q.push_back(tracker.header_b);
        if (shape == SEQ_WRONG_SOURCE) begin
            // sometimes repeat the header where the source belongs
            if (tracker.header_b != tracker.source_b && $urandom_range(0, 1))
                bad = tracker.header_b;
            else
                bad = BYTE_W'($urandom_range(0, 255));
            if (bad == tracker.source_b)
                bad = ~bad;
            q.push_back(bad);
        end else begin
            q.push_back(tracker.source_b);
            q.push_back(BYTE_W'($urandom_range(0, 255)));
            q.push_back(BYTE_W'($urandom_range(0, 255)));
            case (shape)
                SEQ_ZERO_LEN: len = '0;
                SEQ_SHORT: len = BYTE_W'($urandom_range(0, 1) ? STORE_DEPTH - 1
                                                             : $urandom_range(1, 8));
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        len = BYTE_W'(STORE_DEPTH);
                    else if ($urandom_range(0, 7) == 0)
                        len = 8'hFF;
                    else
                        len = BYTE_W'($urandom_range(STORE_DEPTH + 1, 100));
                end
            endcase
            q.push_back(len);
            for (int i = 0; i < len; i++) begin
                if (i % 4 == 0) begin
                    case ($urandom_range(0, 7))
                        0: word = 32'h8000_0000;
                        1: word = 32'h7FFF_FFFF;
                        2: word = 32'h0000_0000;
                        3: word = 32'hFFFF_FFFF;
                        default: word = $urandom;
                    endcase
                end
                q.push_back(word[31 - 8*(i % 4) -: 8]);
            end
            if (shape == SEQ_ZERO_LEN) begin
                if ($urandom_range(0, 1))
                    q.push_back(tracker.header_b);
                else
                    q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                sum = '0;
                foreach (q[j]) sum = sum + q[j];
                if (shape == SEQ_BAD_SUM)
                    sum = sum ^ BYTE_W'($urandom_range(1, 255));
                q.push_back(sum);
            end
        end
        foreach (q[j]) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
            send_beat(KIND_BYTE, q[j]);
        end
    endtask

    // Mostly well-formed frames, the rest broken frames, tick bursts and noise,
    // until the running beat count reaches the given total
    task automatic random_stretch(input int total);
        int pick;
        while (beats_sent < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(SEQ_GOOD);
            else if (pick < 65)
                send_frame(SEQ_BAD_SUM);
            else if (pick < 72)
                send_frame(SEQ_SHORT);
            else if (pick < 77)
                send_frame(SEQ_ZERO_LEN);
            else if (pick < 82)
                send_frame(SEQ_WRONG_SOURCE);
            else if (pick < 91)
                repeat ($urandom_range(1, 6))
                    send_beat(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 4))
                    send_beat(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Drop valid, wait for every owed beat, then let the emitter run dry
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic run_setting(input logic [BYTE_W-1:0] header, input logic [BYTE_W-1:0] source,
                               input logic [TICK_W-1:0] timeout, input int total);
        settle();
        write_reg(CFG_HEADER, CFG_W'(header));
        write_reg(CFG_SOURCE, CFG_W'(source));
        write_reg(CFG_TIMEOUT, timeout);
        random_stretch(total);
    endtask

    initial begin
        tracker          = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_HEADER;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_BYTE;
        in_ch.byte_value = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ticks, idle noise at both byte extremes, then broken frames
        send_beat(KIND_TICK, 8'h00);
        send_beat(KIND_TICK, 8'hFF);
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_BYTE, 8'hFF);
        send_frame(SEQ_WRONG_SOURCE);
        send_frame(SEQ_ZERO_LEN);
        send_frame(SEQ_SHORT);
        random_stretch(100);

        run_setting(8'h00, 8'hFF, 16'd1, 150);
        run_setting(8'hFF, 8'h00, 16'd0, 190);
        run_setting(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                    16'hFFFF, 225);
        run_setting(HEADER_RST, SOURCE_RST, 16'd3, 250);
        settle();

        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
